// ===== rtl/lc3is_pkg.sv =====
// Shared constants and types for the LC-3 instruction step core.
`timescale 1ns / 1ps
`default_nettype none
package lc3is_pkg;

   localparam int ADDR_BITS_DEFAULT = 16;
   localparam int WORD_BITS = 16;

   localparam logic [15:0] START_PC_RESET = 16'h3000;

   localparam logic [3:0] OP_ADD = 4'd1;
   localparam logic [3:0] OP_AND = 4'd5;
   localparam logic [3:0] OP_RTI = 4'd8;
   localparam logic [3:0] OP_LDI = 4'd10;
   localparam logic [3:0] OP_RES = 4'd13;

   localparam logic [2:0] CC_P = 3'd1;
   localparam logic [2:0] CC_Z = 3'd2;
   localparam logic [2:0] CC_N = 3'd4;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_FETCH  = 9'b000000010,
      ST_DECODE = 9'b000000100,
      ST_OPB    = 9'b000001000,
      ST_EXEC   = 9'b000010000,
      ST_PTR    = 9'b000100000,
      ST_IND    = 9'b001000000,
      ST_WRITE  = 9'b010000000,
      ST_RESULT = 9'b100000000
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/lc3_instruction_step.sv =====
// LC-3 instruction step core: sequencer, shared adder, word memory and register file.
//
// Usage: an item on the req_ channel is either a load (req_type 0), which writes
// req_load_data into memory at req_load_address, or a step (req_type 1), which
// fetches the word at the program counter, advances it and executes ADD, AND or
// LDI; RTI and the reserved opcode set a sticky fault, other opcodes only advance
// the program counter. Each item gives one result on the rsp_ channel.
// Timing: one item at a time; req_stall is high while an item is in work.
// Steps pass fetch, decode, operand, execute, result; ADD/AND add write, LDI adds
// pointer, indirect, write; load or halted step goes straight to result. This is
// set by the single synchronous memory read port (fetch plus LDI's two dependent
// reads), the one-read register file and the one adder shared by PC, ADD and LDI.
// Reset: registers and condition code clear, fault clears, and the program counter
// returns to 0x3000; memory holds no defined value until loaded. A csr_ write loads
// the program counter directly, with priority over the advance at decode.
// Stall: a result waits in the rsp_ output register while rsp_stall is high; the
// sequencer holds its finished item until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module lc3_instruction_step #(
   parameter int ADDR_BITS = lc3is_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [15:0] req_load_address,
   input  wire logic [15:0] req_load_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_pc_value,
   output logic [2:0]       rsp_cond_flags,
   output logic             rsp_reg_written,
   output logic [2:0]       rsp_written_index,
   output logic [15:0]      rsp_written_value,
   output logic             rsp_fault,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   localparam int MEM_DEPTH = 1 << ADDR_BITS;

   lc3is_pkg::state_type state_ff, state_in;

   logic [15:0] mem [MEM_DEPTH];
   logic [15:0] rd_data_ff;
   logic [ADDR_BITS-1:0] rd_addr;

   logic [15:0] regs_ff [8];
   logic [2:0]  rf_addr;
   logic [15:0] rf_rd_ff;

   logic [15:0] pc_ff;
   logic [2:0]  cc_ff;
   logic        halted_ff;
   logic [15:0] ins_ff;
   logic [15:0] opb_ff;
   logic [15:0] alu_ff;
   logic [15:0] ptr_ff;
   logic        wrote_ff;
   logic [2:0]  widx_ff;
   logic [15:0] wval_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_pc_ff;
   logic [2:0]  rsp_cc_ff;
   logic        rsp_wrote_ff;
   logic [2:0]  rsp_widx_ff;
   logic [15:0] rsp_wval_ff;
   logic        rsp_fault_ff;

   logic        req_accept;
   logic        out_free;
   logic [3:0]  opcode;
   logic [2:0]  dr;
   logic [15:0] imm5;
   logic [15:0] imm9;
   logic [15:0] add_a;
   logic [15:0] add_b;
   logic [15:0] add_sum;
   logic [15:0] wb_val;
   logic [2:0]  wb_cc;

   assign req_stall  = (state_ff != lc3is_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign opcode = ins_ff[15:12];
   assign dr     = ins_ff[11:9];
   assign imm5   = {{11{ins_ff[4]}}, ins_ff[4:0]};
   assign imm9   = {{7{ins_ff[8]}}, ins_ff[8:0]};

   always_comb begin
      add_a = pc_ff;
      add_b = 16'd1;
      if (state_ff == lc3is_pkg::ST_EXEC) begin
         if (opcode == lc3is_pkg::OP_LDI) begin
            add_b = imm9;
         end else begin
            add_a = rf_rd_ff;
            add_b = opb_ff;
         end
      end
   end
   assign add_sum = add_a + add_b;

   always_comb begin
      unique case (state_ff)
         lc3is_pkg::ST_PTR: rd_addr = ptr_ff[ADDR_BITS-1:0];
         lc3is_pkg::ST_IND: rd_addr = rd_data_ff[ADDR_BITS-1:0];
         default:           rd_addr = pc_ff[ADDR_BITS-1:0];
      endcase
   end

   always_comb begin
      if (state_ff == lc3is_pkg::ST_DECODE) begin
         rf_addr = rd_data_ff[2:0];
      end else begin
         rf_addr = ins_ff[8:6];
      end
   end

   assign wb_val = (opcode == lc3is_pkg::OP_LDI) ? rd_data_ff : alu_ff;

   always_comb begin
      priority if (wb_val == 16'd0) begin
         wb_cc = lc3is_pkg::CC_Z;
      end else if (wb_val[15]) begin
         wb_cc = lc3is_pkg::CC_N;
      end else begin
         wb_cc = lc3is_pkg::CC_P;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lc3is_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_type == lc3is_pkg::REQ_STEP && !halted_ff) begin
                  state_in = lc3is_pkg::ST_FETCH;
               end else begin
                  state_in = lc3is_pkg::ST_RESULT;
               end
            end
         end
         lc3is_pkg::ST_FETCH:  state_in = lc3is_pkg::ST_DECODE;
         lc3is_pkg::ST_DECODE: state_in = lc3is_pkg::ST_OPB;
         lc3is_pkg::ST_OPB:    state_in = lc3is_pkg::ST_EXEC;
         lc3is_pkg::ST_EXEC: begin
            priority if (opcode == lc3is_pkg::OP_LDI) begin
               state_in = lc3is_pkg::ST_PTR;
            end else if (opcode == lc3is_pkg::OP_ADD || opcode == lc3is_pkg::OP_AND) begin
               state_in = lc3is_pkg::ST_WRITE;
            end else begin
               state_in = lc3is_pkg::ST_RESULT;
            end
         end
         lc3is_pkg::ST_PTR:   state_in = lc3is_pkg::ST_IND;
         lc3is_pkg::ST_IND:   state_in = lc3is_pkg::ST_WRITE;
         lc3is_pkg::ST_WRITE: state_in = lc3is_pkg::ST_RESULT;
         lc3is_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = lc3is_pkg::ST_IDLE;
            end
         end
         default: state_in = lc3is_pkg::ST_IDLE;
      endcase
   end

   // word memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_accept && req_type == lc3is_pkg::REQ_LOAD) begin
         mem[req_load_address[ADDR_BITS-1:0]] <= req_load_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      rf_rd_ff <= regs_ff[rf_addr];
      if (state_ff == lc3is_pkg::ST_DECODE) begin
         ins_ff <= rd_data_ff;
      end
      if (state_ff == lc3is_pkg::ST_OPB) begin
         opb_ff <= ins_ff[5] ? imm5 : rf_rd_ff;
      end
      if (state_ff == lc3is_pkg::ST_EXEC) begin
         alu_ff <= (opcode == lc3is_pkg::OP_AND) ? (rf_rd_ff & opb_ff) : add_sum;
         ptr_ff <= add_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lc3is_pkg::ST_IDLE;
         pc_ff       <= lc3is_pkg::START_PC_RESET;
         cc_ff       <= 3'd0;
         halted_ff   <= 1'b0;
         wrote_ff    <= 1'b0;
         widx_ff     <= 3'd0;
         wval_ff     <= 16'd0;
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= 16'd0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            pc_ff <= csr_write_data;
         end else if (state_ff == lc3is_pkg::ST_DECODE) begin
            pc_ff <= add_sum;
         end
         if (req_accept) begin
            wrote_ff <= 1'b0;
            widx_ff  <= 3'd0;
            wval_ff  <= 16'd0;
         end
         if (state_ff == lc3is_pkg::ST_EXEC &&
             (opcode == lc3is_pkg::OP_RTI || opcode == lc3is_pkg::OP_RES)) begin
            halted_ff <= 1'b1;
         end
         if (state_ff == lc3is_pkg::ST_WRITE) begin
            regs_ff[dr] <= wb_val;
            cc_ff       <= wb_cc;
            wrote_ff    <= 1'b1;
            widx_ff     <= dr;
            wval_ff     <= wb_val;
         end
      end
   end

   // output register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == lc3is_pkg::ST_RESULT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == lc3is_pkg::ST_RESULT && out_free) begin
         rsp_pc_ff    <= pc_ff;
         rsp_cc_ff    <= cc_ff;
         rsp_wrote_ff <= wrote_ff;
         rsp_widx_ff  <= widx_ff;
         rsp_wval_ff  <= wval_ff;
         rsp_fault_ff <= halted_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pc_value      = rsp_pc_ff;
   assign rsp_cond_flags    = rsp_cc_ff;
   assign rsp_reg_written   = rsp_wrote_ff;
   assign rsp_written_index = rsp_widx_ff;
   assign rsp_written_value = rsp_wval_ff;
   assign rsp_fault         = rsp_fault_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("fault flag cleared without reset");

   a_halted_step_skips: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_type == lc3is_pkg::REQ_STEP && halted_ff)
         |=> state_ff == lc3is_pkg::ST_RESULT)
      else $error("halted step entered execution");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == lc3is_pkg::ST_RESULT)
      else $error("item issued outside result state");

   a_write_has_dest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lc3is_pkg::ST_WRITE) |=> wrote_ff && widx_ff == $past(dr))
      else $error("register write not recorded");

endmodule
`default_nettype wire
